// File: src/pulse_period_averager_macros.svh
// Assertion macros shared by the pulse period averager RTL.
`ifndef PULSE_PERIOD_AVERAGER_MACROS_SVH
`define PULSE_PERIOD_AVERAGER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ppa_pkg.sv
// Shared types and constants of the pulse period averager.
package ppa_pkg;

  localparam int DEF_MAX_WINDOW   = 32;
  localparam int DEF_SPACING_BITS = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING = 2'd1;

  localparam logic [2:0]  RST_WINDOW_LOG2 = 3'd2;
  localparam logic [31:0] RST_MIN_SPACING = 32'd2500000;

  typedef enum logic [1:0] {
    KIND_EDGE         = 2'd0,
    KIND_TIMEOUT      = 2'd1,
    KIND_PRESET_COUNT = 2'd2,
    KIND_PRESET_AVG   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] timestamp_ns;
    logic [31:0] preset_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] spacing_count;
    logic [31:0] spacing_average;
    logic        edge_accepted;
    logic        restart_timeout;
  } out_item_t;

  // Controller -> ring
  typedef struct packed {
    logic wr;
    logic clear;
    logic sum_start;
  } ring_ctrl_t;

  // Ring -> controller
  typedef struct packed {
    logic busy;
    logic done;
  } ring_stat_t;

endpackage

// File: src/ppa_chan_if.sv
// Valid/ready word channel used for the input and result streams.
interface ppa_chan_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ppa_ram.sv
// Generic simple dual-port RAM with registered read.
module ppa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: src/ppa_ring.sv
// Spacing ring: RAM, per-entry valid bits and the window sum sequencer.
module ppa_ring #(
  parameter int MAX_WINDOW   = ppa_pkg::DEF_MAX_WINDOW,
  parameter int SPACING_BITS = ppa_pkg::DEF_SPACING_BITS,
  parameter int IDX_W        = $clog2(MAX_WINDOW),
  parameter int CNT_W        = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W        = (SPACING_BITS + CNT_W > 64) ? 64 : SPACING_BITS + CNT_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ppa_pkg::ring_ctrl_t     ctrl,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [SPACING_BITS-1:0] wr_data,
  input  logic [CNT_W-1:0]        win_len,
  output ppa_pkg::ring_stat_t     stat,
  output logic [SUM_W-1:0]        sum
);
  import ppa_pkg::*;

  logic [MAX_WINDOW-1:0]   valid_r;
  logic                    rvld_r;
  logic [SPACING_BITS-1:0] rdata;
  logic [IDX_W-1:0]        rd_addr;

  logic             busy_r, busy_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;

  assign rd_addr = cnt_r[IDX_W-1:0];

  ppa_ram #(
    .WIDTH (SPACING_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.wr),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Entries never written since reset or timeout read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctrl.clear) begin
      valid_r <= '0;
    end else if (ctrl.wr) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rvld_r <= valid_r[rd_addr];
    acc_r  <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // One read issued per cycle while the sum runs, its data added in the cycle after.
  always_comb begin
    busy_nxt = busy_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    if (ctrl.sum_start) begin
      busy_nxt = 1'b1;
      pend_nxt = 1'b0;
      cnt_nxt  = '0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (pend_r) begin
        acc_nxt = acc_r + SUM_W'(rvld_r ? rdata : '0);
      end
      if (cnt_r < win_len) begin
        cnt_nxt  = cnt_r + CNT_W'(1);
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
        if (!pend_r) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == win_len) && !pend_r;
  assign sum       = acc_r;
endmodule

// File: src/pulse_period_averager.sv
// Pulse period averager top level: control FSM, state registers, result register.
// A word passes IDLE, EVAL and EMIT, and also SUM when the average is recomputed, the
//   window sum reading one ring entry per cycle from the ring RAM port.
// A new word is taken only in IDLE, after the result of the last one is registered.
// Reset: synchronous, rst_n low; ring valid bits clear at once, no clearing pass.
module pulse_period_averager #(
  parameter int MAX_WINDOW   = ppa_pkg::DEF_MAX_WINDOW,
  parameter int SPACING_BITS = ppa_pkg::DEF_SPACING_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ppa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ppa_chan_if.sink                        in_chan,
  ppa_chan_if.source                      out_chan
);
  import ppa_pkg::*;

  `include "pulse_period_averager_macros.svh"

  localparam int IDX_W    = $clog2(MAX_WINDOW);
  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W    = (SPACING_BITS + CNT_W > 64) ? 64 : SPACING_BITS + CNT_W;
  // Largest log2 whose window still fits in the ring (field is 3 bits).
  localparam int WLOG_FIT = $clog2(MAX_WINDOW + 1) - 1;
  localparam logic [2:0] WLOG_MAX = (WLOG_FIT > 7) ? 3'd7 : 3'(WLOG_FIT);

  function automatic logic [2:0] clamp_log2(input logic [2:0] v);
    return (v > WLOG_MAX) ? WLOG_MAX : v;
  endfunction

  state_t     st_r, st_nxt;
  in_item_t   item_r, item_nxt;
  logic [2:0] wl_r, wl_nxt;
  logic [31:0] min_sp_r, min_sp_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0] avg_r, avg_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [63:0] last_r, last_nxt;
  logic        seen_r, seen_nxt;
  logic        acc_r, acc_nxt;
  logic        rst_flag_r, rst_flag_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  ring_ctrl_t            rctrl;
  ring_stat_t            rstat;
  logic [SUM_W-1:0]      rsum;
  logic [SUM_W-1:0]      sum_shift;
  logic [CNT_W-1:0]      win;
  logic [63:0]           sp;
  logic                  sp_pass;
  logic                  sp_over;
  logic [SPACING_BITS-1:0] sp_sat;

  assign win = CNT_W'(1) << wl_r;

  // Spacing since last accepted edge, 64-bit wrap, saturated to the ring width.
  assign sp      = item_r.timestamp_ns - last_r;
  assign sp_pass = sp >= {32'd0, min_sp_r};
  assign sp_over = |(sp >> SPACING_BITS);
  assign sp_sat  = sp_over ? '1 : sp[SPACING_BITS-1:0];

  assign sum_shift = rsum >> wl_r;

  ppa_ring #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SPACING_BITS (SPACING_BITS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rctrl),
    .wr_addr (idx_r),
    .wr_data (sp_sat),
    .win_len (win),
    .stat    (rstat),
    .sum     (rsum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wl_r        <= clamp_log2(RST_WINDOW_LOG2);
      min_sp_r    <= RST_MIN_SPACING;
      idx_r       <= '0;
      avg_r       <= '0;
      cnt_r       <= '0;
      last_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      wl_r        <= wl_nxt;
      min_sp_r    <= min_sp_nxt;
      idx_r       <= idx_nxt;
      avg_r       <= avg_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    acc_r      <= acc_nxt;
    rst_flag_r <= rst_flag_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    st_nxt        = st_r;
    item_nxt      = item_r;
    wl_nxt        = wl_r;
    min_sp_nxt    = min_sp_r;
    idx_nxt       = idx_r;
    avg_nxt       = avg_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    seen_nxt      = seen_r;
    acc_nxt       = acc_r;
    rst_flag_nxt  = rst_flag_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rctrl         = '0;

    // Config writes must arrive only while idle; the block itself does not enforce it.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LOG2: begin
          wl_nxt  = clamp_log2(cfg_wdata[2:0]);
          idx_nxt = '0;
          avg_nxt = '0;
          cnt_nxt = '0;
        end
        REG_MIN_SPACING: begin
          min_sp_nxt = cfg_wdata;
        end
        default: ;
      endcase
    end

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          item_nxt = in_chan.data;
          st_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        acc_nxt      = 1'b0;
        rst_flag_nxt = 1'b0;
        st_nxt       = ST_EMIT;
        unique case (kind_t'(item_r.kind))
          KIND_EDGE: begin
            if (!seen_r) begin
              // first edge only records its time
              last_nxt     = item_r.timestamp_ns;
              seen_nxt     = 1'b1;
              acc_nxt      = 1'b1;
              rst_flag_nxt = 1'b1;
            end else if (sp_pass) begin
              rctrl.wr     = 1'b1;
              idx_nxt      = (idx_r + IDX_W'(1)) & IDX_W'(win - CNT_W'(1));
              cnt_nxt      = cnt_r + 32'd1;
              last_nxt     = item_r.timestamp_ns;
              acc_nxt      = 1'b1;
              rst_flag_nxt = 1'b1;
              // Sum starts the cycle after the write lands, so no forwarding.
              if (cnt_r > 32'(win)) begin
                rctrl.sum_start = 1'b1;
                st_nxt          = ST_SUM;
              end
            end
          end
          KIND_TIMEOUT: begin
            avg_nxt      = '0;
            idx_nxt      = '0;
            rctrl.clear  = 1'b1;
            rst_flag_nxt = 1'b1;
          end
          KIND_PRESET_COUNT: begin
            cnt_nxt = item_r.preset_value;
          end
          KIND_PRESET_AVG: begin
            avg_nxt = item_r.preset_value;
          end
          default: ;
        endcase
      end
      ST_SUM: begin
        if (rstat.done) begin
          avg_nxt = 32'(sum_shift);
          st_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Waits here only while the previous result is still held.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.spacing_count   = cnt_r;
          out_data_nxt.spacing_average = avg_r;
          out_data_nxt.edge_accepted   = acc_r;
          out_data_nxt.restart_timeout = rst_flag_r;
          st_nxt                       = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // No word is taken while reset is held.
  assign in_chan.ready  = rst_n && (st_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  `PPA_ASSERT_NOW(a_idle_ring_quiet, st_r == ST_IDLE, !rstat.busy, "ring busy while idle")
  `PPA_ASSERT_NOW(a_sum_done_in_sum, rstat.done, st_r == ST_SUM, "sum done outside sum state")
  `PPA_ASSERT_NOW(a_idx_in_window, 1'b1, CNT_W'(idx_r) < win, "ring index outside window")
  `PPA_ASSERT_NOW(a_accept_restarts, out_valid_r && out_data_r.edge_accepted, out_data_r.restart_timeout, "accepted edge without restart")
  `PPA_ASSERT_NEXT(a_sum_after_start, rctrl.sum_start, rstat.busy && (st_r == ST_SUM), "sum not running after start")
endmodule
